@@ rtl/fpcb_pkg.sv @@
package fpcb_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 32;
  localparam int CORDIC_STEPS   = 18;
  localparam int STEP_BITS      = 5;
  localparam int CORDIC_W       = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [1:0] OP_ROTATE = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_SETPOS = 2'd2;

  // Arctangent of 2^-i, in 2^-32 turn units.
  function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
    case (i)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004757;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      default: atan_turn = 32'd0;
    endcase
  endfunction

endpackage

@@ rtl/fpcb_in_if.sv @@
interface fpcb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] yaw_delta;
  logic signed [15:0] pitch_delta;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  modport source (output valid, opcode, yaw_delta, pitch_delta, offset_x, offset_y,
                  offset_z, input ready);
  modport sink (input valid, opcode, yaw_delta, pitch_delta, offset_x, offset_y,
                offset_z, output ready);
endinterface

@@ rtl/fpcb_out_if.sv @@
interface fpcb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] look_x;
  logic signed [15:0] look_y;
  logic signed [15:0] look_z;
  logic signed [15:0] right_x;
  logic               right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic [14:0]        up_y;
  logic signed [15:0] up_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  modport source (output valid, look_x, look_y, look_z, right_x, right_y, right_z,
                  up_x, up_y, up_z, target_x, target_y, target_z, input ready);
  modport sink (input valid, look_x, look_y, look_z, right_x, right_y, right_z,
                up_x, up_y, up_z, target_x, target_y, target_z, output ready);
endinterface

@@ rtl/first_person_camera_basis_top.sv @@
// First-person camera basis.
// The input channel takes beats of opcode, yaw and pitch deltas and a 3-D offset.
// Rotate updates heading (wraps) and elevation (clamped near a quarter turn);
// move adds the offset to the position; set position overwrites it with no result.
// Rotate and move each give one output beat: look, right and up in Q1.14 and
// the target point (position plus look) in Q16.16.
// One shared CORDIC rotator with a single adder set works one step per cycle:
// a load and 18 steps for the heading, the same for the elevation, then four
// products from one shared multiplier and a store of the result. A new beat is
// not accepted while a rotate or move item is still in the arithmetic; set
// position and the unused opcode need no arithmetic.
// The result sits in an output register; the next input beat is accepted as
// soon as the arithmetic is free, even while the result still waits. A stalled
// receiver holds the block only when a new result is ready to be stored.
// Reset (synchronous, rst high) sets heading to half a turn, elevation and
// position to zero, and empties the output register.
module first_person_camera_basis_top #(
  parameter int ANGLE_BITS = fpcb_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS   = fpcb_pkg::POS_BITS_DEF
) (
  input logic clk,
  input logic rst,
  fpcb_in_if.sink    in_ch,
  fpcb_out_if.source out_ch
);
  localparam int W = fpcb_pkg::CORDIC_W;
  localparam int SB = fpcb_pkg::STEP_BITS;
  // The elevation sum is wide enough for both the state and the 16-bit delta.
  localparam int EW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam logic [63:0] MARGIN =
    ((64'd68356528 << ANGLE_BITS) + 64'd2147483648) >> 32;
  localparam logic signed [EW-1:0] LIMIT =
    EW'((64'd1 << (ANGLE_BITS-2)) - MARGIN);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ITER, S_MUL, S_DONE} state_t;

  state_t state;
  logic              second;
  logic [SB-1:0]     step;
  logic [1:0]        mstep;
  logic [ANGLE_BITS-1:0] heading;
  logic signed [ANGLE_BITS-1:0] elevation;
  logic [POS_BITS-1:0] place [3];
  logic signed [W-1:0] cx, cy_r, cz;
  logic          cneg;
  logic signed [15:0] cos_y, sin_y, cos_p, sin_p;
  logic signed [15:0] lx, lz, ux, uz;
  logic          out_valid;
  logic          load_out;

  // Angle to be resolved now, extended to 32-bit turn units.
  logic [ANGLE_BITS-1:0] ang;
  logic signed [31:0] z32;
  logic signed [W-1:0] zinit;
  logic          neg_init;
  always_comb begin
    ang = second ? elevation : heading;
    z32 = 32'(ang) << (32 - ANGLE_BITS);
    neg_init = 1'b0;
    zinit = W'(z32);
    if (z32 > 32'sd1073741824) begin
      zinit = W'(z32) - W'(34'sd2147483648);
      neg_init = 1'b1;
    end else if (z32 < -32'sd1073741824) begin
      zinit = W'(z32) + W'(34'sd2147483648);
      neg_init = 1'b1;
    end
  end

  // Shared CORDIC step.
  logic signed [W-1:0] dx, dy, at, nx, ny, nz;
  always_comb begin
    dx = cy_r >>> step;
    dy = cx >>> step;
    at = W'(fpcb_pkg::atan_turn(step));
    if (!cz[W-1]) begin
      nx = cx - dx; ny = cy_r + dy; nz = cz - at;
    end else begin
      nx = cx + dx; ny = cy_r - dy; nz = cz + at;
    end
  end

  // Round to Q1.14 and clamp, with the quadrant sign fold.
  function automatic logic signed [15:0] to_q14(input logic signed [W-1:0] v,
                                                input logic n);
    logic signed [W-1:0] r;
    r = (v + W'(32768)) >>> 16;
    if (r > W'(16384)) r = W'(16384);
    if (r < -W'(16384)) r = -W'(16384);
    to_q14 = n ? -16'(r) : 16'(r);
  endfunction

  // Shared multiplier with half-up rounding.
  logic signed [15:0] ma, mb;
  logic signed [31:0] mp;
  logic signed [15:0] mres;
  always_comb begin
    case (mstep)
      2'd0: begin ma = cos_p; mb = sin_y; end
      2'd1: begin ma = cos_p; mb = cos_y; end
      2'd2: begin ma = sin_p; mb = sin_y; end
      default: begin ma = sin_p; mb = cos_y; end
    endcase
    mp = ma * mb + 32'sd8192;
    mres = 16'(mp >>> 14);
  end

  logic signed [EW-1:0] esum;
  logic signed [15:0] cval, sval;
  always_comb begin
    esum = EW'(elevation) + EW'(in_ch.pitch_delta);
    if (esum > LIMIT) esum = LIMIT;
    if (esum < -LIMIT) esum = -LIMIT;
    cval = to_q14(nx, cneg);
    sval = to_q14(ny, cneg);
  end

  assign in_ch.ready = (state == S_IDLE);

  // A finished result is stored when the output register is free or draining.
  assign load_out = (state == S_DONE) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heading <= ANGLE_BITS'(1) << (ANGLE_BITS-1);
      elevation <= '0;
      for (int i = 0; i < 3; i++) place[i] <= '0;
      out_valid <= 1'b0;
      second <= 1'b0;
      step <= '0;
      mstep <= '0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            case (in_ch.opcode)
              fpcb_pkg::OP_ROTATE: begin
                heading <= heading + ANGLE_BITS'(in_ch.yaw_delta);
                elevation <= ANGLE_BITS'(esum);
                state <= S_LOAD;
              end
              fpcb_pkg::OP_MOVE: begin
                place[0] <= place[0] + POS_BITS'(in_ch.offset_x);
                place[1] <= place[1] + POS_BITS'(in_ch.offset_y);
                place[2] <= place[2] + POS_BITS'(in_ch.offset_z);
                state <= S_LOAD;
              end
              fpcb_pkg::OP_SETPOS: begin
                place[0] <= POS_BITS'(in_ch.offset_x);
                place[1] <= POS_BITS'(in_ch.offset_y);
                place[2] <= POS_BITS'(in_ch.offset_z);
              end
              default: ;
            endcase
            second <= 1'b0;
          end
        end
        S_LOAD: begin
          cx <= fpcb_pkg::CORDIC_X0;
          cy_r <= '0;
          cz <= zinit;
          cneg <= neg_init;
          step <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          cx <= nx; cy_r <= ny; cz <= nz;
          step <= step + SB'(1);
          if (step == SB'(fpcb_pkg::CORDIC_STEPS - 1)) begin
            if (!second) begin
              cos_y <= cval; sin_y <= sval;
              second <= 1'b1;
              state <= S_LOAD;
            end else begin
              cos_p <= (cval < 0) ? 16'sd0 : cval;
              sin_p <= sval;
              mstep <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0: lx <= mres;
            2'd1: lz <= mres;
            2'd2: ux <= -mres;
            default: uz <= -mres;
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_ch.look_x <= lx;
            out_ch.look_y <= sin_p;
            out_ch.look_z <= lz;
            out_ch.right_x <= -cos_y;
            out_ch.right_z <= sin_y;
            out_ch.up_x <= ux;
            out_ch.up_y <= 15'(cos_p);
            out_ch.up_z <= uz;
            out_ch.target_x <= 32'(place[0] + POS_BITS'(lx) * POS_BITS'(4));
            out_ch.target_y <= 32'(place[1] + POS_BITS'(sin_p) * POS_BITS'(4));
            out_ch.target_z <= 32'(place[2] + POS_BITS'(lz) * POS_BITS'(4));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.right_y = 1'b0;

endmodule

@@ rtl/fpcb_checker.sv @@
module fpcb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic right_y,
  input logic signed [15:0] look_y
);
  // A held output beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output beat dropped");
  // The right vector never leaves the horizontal plane.
  a_ry: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !right_y) else $error("right_y set");
  // A held output beat keeps its look y payload.
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(look_y)) else $error("payload changed");
  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
  // Look y stays in Q1.14 range.
  a_ly: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (look_y <= 16'sd16384 && look_y >= -16'sd16384)) else $error("range");
endmodule

bind first_person_camera_basis_top fpcb_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .right_y(out_ch.right_y), .look_y(out_ch.look_y)
);
